/* src/rlu_pkg.sv */
// Shared types and constants of the register logic unit.
// Holds the command and result word types and the operation codes.
// Depends on nothing.
package rlu_pkg;

    // Operation codes carried in the op field of a command word.
    localparam logic [3:0] OP_AND   = 4'd0;
    localparam logic [3:0] OP_ANDI  = 4'd1;
    localparam logic [3:0] OP_OR    = 4'd2;
    localparam logic [3:0] OP_ORI   = 4'd3;
    localparam logic [3:0] OP_XOR   = 4'd4;
    localparam logic [3:0] OP_XORI  = 4'd5;
    localparam logic [3:0] OP_NOT   = 4'd6;
    localparam logic [3:0] OP_NOTI  = 4'd7;
    localparam logic [3:0] OP_NAND  = 4'd8;
    localparam logic [3:0] OP_NANDI = 4'd9;
    localparam logic [3:0] OP_NOR   = 4'd10;
    localparam logic [3:0] OP_NORI  = 4'd11;
    localparam logic [3:0] OP_SHL   = 4'd12;
    localparam logic [3:0] OP_LOAD  = 4'd13;

    // Result status codes.
    localparam logic ST_DONE    = 1'b0;
    localparam logic ST_BAD_REG = 1'b1;

    // Width of a short immediate.
    localparam int IMM_BITS = 8;

    // Width of one register.
    localparam int DATA_W = 32;

    // One command word.
    typedef struct packed {
        logic [3:0]               op;
        logic [7:0]               dest_index;
        logic [7:0]               first_byte;
        logic [7:0]               second_byte;
        logic signed [DATA_W-1:0] load_value;
    } cmd_word_t;

    // One result word.
    typedef struct packed {
        logic                     status;
        logic signed [DATA_W-1:0] written_value;
    } res_word_t;

    // Operand usage of one operation.
    typedef struct packed {
        logic legal;
        logic use_a;
        logic use_b;
    } op_use_t;

    // Decode which register operands an operation reads.
    function automatic op_use_t decode_use(input logic [3:0] op);
        op_use_t u;
        u = '0;
        case (op) inside
            OP_AND, OP_OR, OP_XOR, OP_NAND, OP_NOR, OP_SHL:
            begin
                u.legal = 1'b1;
                u.use_a = 1'b1;
                u.use_b = 1'b1;
            end
            OP_ANDI, OP_ORI, OP_XORI, OP_NOT, OP_NANDI, OP_NORI:
            begin
                u.legal = 1'b1;
                u.use_a = 1'b1;
            end
            OP_NOTI, OP_LOAD:
            begin
                u.legal = 1'b1;
            end
            default:
            begin
                u = '0;
            end
        endcase
        return u;
    endfunction

endpackage

/* src/register_logic_unit_core.sv */
// Top level of the register logic unit: command control, register file and
// logic operation unit. Depends on rlu_pkg, rlu_regfile and rlu_alu.
//
//  channel   | ports                 | handshake
//  ----------+-----------------------+---------------------------------------
//  command   | start, busy, command  | word taken when start high, busy low
//  result    | done, result          | word valid for one cycle while done high
//
// For each command word, the register file is read on the edge that takes the
// word, and the result is written back and registered on the next. busy is
// high for a single cycle, and no new word is taken while it is high; done
// rises in the cycle after busy and may overlap the next start.
// Reset clears all control state and marks every register as zero; no clearing
// pass is needed. The receiver cannot stall, so results never wait.
module register_logic_unit_core
    import rlu_pkg::*;
#(
    parameter int REG_COUNT = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  cmd_word_t command,
    output logic      done,
    output res_word_t result
);

    localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    logic              accept;
    op_use_t           use_ops;
    logic              bad;
    logic              exec_reg;
    logic              bad_reg;
    cmd_word_t         cmd_reg;
    logic              done_reg;
    res_word_t         result_reg;
    logic [DATA_W-1:0] reg_a;
    logic [DATA_W-1:0] reg_b;
    logic [DATA_W-1:0] alu_result;
    logic              wr_en;

    assign accept = start && !busy;

    // Opcode and register number checks for the incoming word.
    assign use_ops = decode_use(command.op);
    always_comb
    begin
        bad = !use_ops.legal
            || ({1'b0, command.dest_index} >= 9'(REG_COUNT))
            || (use_ops.use_a && ({1'b0, command.first_byte} >= 9'(REG_COUNT)))
            || (use_ops.use_b && ({1'b0, command.second_byte} >= 9'(REG_COUNT)));
    end

    // Control: the execute flag for each taken word, then the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_reg <= 1'b0;
            done_reg <= 1'b0;
            bad_reg  <= 1'b0;
        end
        else
        begin
            exec_reg <= accept;
            done_reg <= exec_reg;
            if (accept)
            begin
                bad_reg <= bad;
            end
        end
    end

    // Payload registers: the held command and the result word.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
        end
        if (exec_reg)
        begin
            result_reg.status        <= bad_reg ? ST_BAD_REG : ST_DONE;
            result_reg.written_value <= bad_reg ? '0 : alu_result;
        end
    end

    assign wr_en = exec_reg && !bad_reg;

    rlu_regfile #(
        .REG_COUNT (REG_COUNT),
        .IDX_W     (IDX_W)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_a (command.first_byte[IDX_W-1:0]),
        .rd_addr_b (command.second_byte[IDX_W-1:0]),
        .rd_data_a (reg_a),
        .rd_data_b (reg_b),
        .wr_en     (wr_en),
        .wr_addr   (cmd_reg.dest_index[IDX_W-1:0]),
        .wr_data   (alu_result)
    );

    rlu_alu u_alu (
        .cmd    (cmd_reg),
        .reg_a  (reg_a),
        .reg_b  (reg_b),
        .result (alu_result)
    );

    assign busy   = exec_reg;
    assign done   = done_reg;
    assign result = result_reg;

    // A word that is taken is executed in the very next cycle.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
    else $error("accepted word was not executed");

    // Execution lasts exactly one cycle.
    a_exec_once: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
    else $error("execute cycle repeated");

    // Every result strobe follows an execute cycle.
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
    else $error("result strobe without execution");

    // A bad register number reports a zero value.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_BAD_REG) |-> result.written_value == '0)
    else $error("error result carries a value");

endmodule

/* src/rlu_regfile.sv */
// Register file of the register logic unit: a synchronous memory with two
// registered read ports and one write port, plus per-entry valid bits.
// Depends on rlu_pkg.
module rlu_regfile
    import rlu_pkg::*;
#(
    parameter int REG_COUNT = 32,
    parameter int IDX_W     = $clog2(REG_COUNT)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr_a,
    input  logic [IDX_W-1:0]  rd_addr_b,
    output logic [DATA_W-1:0] rd_data_a,
    output logic [DATA_W-1:0] rd_data_b,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [REG_COUNT];
    logic [REG_COUNT-1:0] vld_reg;
    logic [DATA_W-1:0] data_a_reg;
    logic [DATA_W-1:0] data_b_reg;
    logic vld_a_reg;
    logic vld_b_reg;

    // Storage array and registered read data; no reset on the payload.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_a_reg <= mem[rd_addr_a];
            data_b_reg <= mem[rd_addr_b];
        end
    end

    // Valid bits stand for the all-zero reset contents of the file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                vld_a_reg <= vld_reg[rd_addr_a];
                vld_b_reg <= vld_reg[rd_addr_b];
            end
        end
    end

    // An entry that was never written reads as zero.
    assign rd_data_a = vld_a_reg ? data_a_reg : '0;
    assign rd_data_b = vld_b_reg ? data_b_reg : '0;

endmodule

/* src/rlu_alu.sv */
// Logic operation unit of the register logic unit: forms the result of one
// command word from the register operands and the immediates.
// Depends on rlu_pkg.
module rlu_alu
    import rlu_pkg::*;
(
    input  cmd_word_t         cmd,
    input  logic [DATA_W-1:0] reg_a,
    input  logic [DATA_W-1:0] reg_b,
    output logic [DATA_W-1:0] result
);

    op_use_t           use_ops;
    logic [DATA_W-1:0] vb;
    logic [DATA_W-1:0] imm16;

    assign use_ops = decode_use(cmd.op);

    // The second operand is a register or the zero-extended byte.
    assign vb    = use_ops.use_b ? reg_b : DATA_W'(cmd.second_byte);
    assign imm16 = DATA_W'({cmd.first_byte, cmd.second_byte});

    // Operation select.
    always_comb
    begin
        case (cmd.op) inside
            OP_AND, OP_ANDI:   result = reg_a & vb;
            OP_OR, OP_ORI:     result = reg_a | vb;
            OP_XOR, OP_XORI:   result = reg_a ^ vb;
            OP_NOT:            result = ~reg_a;
            OP_NOTI:           result = ~imm16;
            OP_NAND, OP_NANDI: result = ~(reg_a & vb);
            OP_NOR, OP_NORI:   result = ~(reg_a | vb);
            OP_SHL:            result = reg_a << vb[4:0];
            default:           result = cmd.load_value;
        endcase
    end

endmodule
